// ===== rtl/mprq_pkg.sv =====
`default_nettype none

package mprq_pkg;

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 4;
   localparam int LEVEL_W  = 3;
   localparam int STATUS_W = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ENQ_TAIL = 2'd0,
      FUNC_ENQ_HEAD = 2'd1,
      FUNC_DISPATCH = 2'd2
   } mprq_func_type;

   typedef enum logic [STATUS_W-1:0] {
      RSP_DONE  = 2'd0,
      RSP_EMPTY = 2'd1,
      RSP_DUP   = 2'd2
   } mprq_rsp_type;

   typedef enum logic [1:0] {
      STATE_IDLE,
      STATE_EXEC,
      STATE_LINK
   } mprq_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture request, read head/tail of selected level
      logic link_rd;      // read successor of the dispatched head
      logic finish;       // commit enqueue, short dispatch or no-op
      logic finish_link;  // commit dispatch that advances the head
   } mprq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic disp_link;    // dispatch needs the successor link
      logic out_busy;     // result register holds an untaken result
   } mprq_stat_type;

endpackage

`default_nettype wire

// ===== rtl/multilevel_priority_ready_queue_unit.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  req_func, req_proc_id, req_proc_level
// rsp_      out        rsp_valid/rsp_stall  rsp_status, rsp_chosen_id
//
// Enqueues and dispatches from a level holding one entry commit after the
// registered read of the head/tail memories; a dispatch that advances the
// level head commits after that read and then the registered link read.
// Reset clears state, queued, non-empty and valid flags; no memory clearing.
// A stalled result holds the commit step; a new request is taken while a
// result waits in the output register.
`default_nettype none

module multilevel_priority_ready_queue_unit
   import mprq_pkg::*;
#(
   parameter int NUM_ENTRIES = 16,
   parameter int NUM_LEVELS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ID_W-1:0]     req_proc_id,
   input  logic [LEVEL_W-1:0]  req_proc_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_chosen_id
);

   mprq_cmd_type  cmd;
   mprq_stat_type stat;

   mprq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mprq_datapath #(
      .NUM_ENTRIES (NUM_ENTRIES),
      .NUM_LEVELS  (NUM_LEVELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_func       (req_func),
      .req_proc_id    (req_proc_id),
      .req_proc_level (req_proc_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_chosen_id  (rsp_chosen_id)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous one still in progress");

   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in progress");

   a_empty_id_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == RSP_EMPTY)) |-> (rsp_chosen_id == '0))
      else $error("empty dispatch returned a nonzero id");

endmodule

`default_nettype wire

// ===== rtl/mprq_ctrl.sv =====
`default_nettype none

module mprq_ctrl
   import mprq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  mprq_stat_type stat,
   output mprq_cmd_type  cmd
);

   mprq_state_type state_ff;
   mprq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         STATE_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            // hold until the result register can take a new result
            if (!stat.out_busy) begin
               if (stat.disp_link) begin
                  cmd.link_rd = 1'b1;
                  state_in    = STATE_LINK;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = STATE_IDLE;
               end
            end
         end
         STATE_LINK: begin
            if (!stat.out_busy) begin
               cmd.finish_link = 1'b1;
               state_in        = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/mprq_datapath.sv =====
`default_nettype none

module mprq_datapath
   import mprq_pkg::*;
#(
   parameter int NUM_ENTRIES = 16,
   parameter int NUM_LEVELS  = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  mprq_cmd_type        cmd,
   output mprq_stat_type       stat,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ID_W-1:0]     req_proc_id,
   input  logic [LEVEL_W-1:0]  req_proc_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ID_W-1:0]     rsp_chosen_id
);

   localparam int EntW = $clog2(NUM_ENTRIES);
   localparam int LvlW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

   function automatic logic [EntW-1:0] ent_idx(input logic [ID_W-1:0] id);
      logic [EntW+ID_W-1:0] wide;
      wide = {{EntW{1'b0}}, id};
      return wide[EntW-1:0];
   endfunction

   function automatic logic [LvlW-1:0] lvl_idx(input logic [LEVEL_W-1:0] lvl);
      logic [LvlW+LEVEL_W-1:0] wide;
      wide = {{LvlW{1'b0}}, lvl};
      return wide[LvlW-1:0];
   endfunction

   // link and level memories
   logic [ID_W-1:0] link_ff [NUM_ENTRIES];
   logic [ID_W-1:0] head_ff [NUM_LEVELS];
   logic [ID_W-1:0] tail_ff [NUM_LEVELS];

   logic [NUM_ENTRIES-1:0] queued_ff;
   logic [NUM_ENTRIES-1:0] queued_in;
   logic [NUM_LEVELS-1:0]  nonempty_ff;
   logic [NUM_LEVELS-1:0]  nonempty_in;

   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   id_ff;
   logic [LvlW-1:0]   level_ff;
   logic              found_ff;
   logic              range_ok_ff;
   logic [ID_W-1:0]   head_rd_ff;
   logic [ID_W-1:0]   tail_rd_ff;
   logic [ID_W-1:0]   link_rd_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_chosen_ff;

   logic [LvlW-1:0] enc_level;
   logic [LvlW-1:0] sel_level;
   logic            req_is_disp;
   logic            is_disp;
   logic            is_enq;
   logic            lvl_ne;
   logic            is_dup;
   logic            enq_do;
   logic            disp_last;
   logic [EntW-1:0] id_e;
   logic [EntW-1:0] head_e;
   logic [EntW-1:0] tail_e;
   logic [STATUS_W-1:0] res_status;
   logic [ID_W-1:0]     res_id;

   // lowest-numbered non-empty level
   always_comb begin
      enc_level = '0;
      for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
         if (nonempty_ff[i]) begin
            enc_level = LvlW'(i);
         end
      end
   end

   assign req_is_disp = (req_func == FUNC_DISPATCH);
   assign sel_level   = req_is_disp ? enc_level : lvl_idx(req_proc_level);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         id_ff       <= req_proc_id;
         level_ff    <= sel_level;
         found_ff    <= |nonempty_ff;
         range_ok_ff <= (int'(req_proc_id) < NUM_ENTRIES) &&
                        (int'(req_proc_level) < NUM_LEVELS);
         head_rd_ff  <= head_ff[sel_level];
         tail_rd_ff  <= tail_ff[sel_level];
      end
      if (cmd.link_rd) begin
         link_rd_ff <= link_ff[head_e];
      end
   end

   assign is_disp = (func_ff == FUNC_DISPATCH);
   assign is_enq  = (func_ff == FUNC_ENQ_TAIL) || (func_ff == FUNC_ENQ_HEAD);
   assign id_e    = ent_idx(id_ff);
   assign head_e  = ent_idx(head_rd_ff);
   assign tail_e  = ent_idx(tail_rd_ff);
   assign lvl_ne  = nonempty_ff[level_ff];
   assign is_dup  = queued_ff[id_e];

   assign enq_do    = cmd.finish && is_enq && range_ok_ff && !is_dup;
   assign disp_last = cmd.finish && is_disp && found_ff;

   always_ff @(posedge clock) begin
      if (enq_do) begin
         if (!lvl_ne) begin
            head_ff[level_ff] <= id_ff;
            tail_ff[level_ff] <= id_ff;
         end else if (func_ff == FUNC_ENQ_TAIL) begin
            link_ff[tail_e]   <= id_ff;
            tail_ff[level_ff] <= id_ff;
         end else begin
            link_ff[id_e]     <= head_rd_ff;
            head_ff[level_ff] <= id_ff;
         end
      end
      if (cmd.finish_link) begin
         head_ff[level_ff] <= link_rd_ff;
      end
   end

   always_comb begin
      queued_in   = queued_ff;
      nonempty_in = nonempty_ff;
      if (enq_do) begin
         queued_in[id_e]       = 1'b1;
         nonempty_in[level_ff] = 1'b1;
      end
      if (disp_last) begin
         queued_in[head_e]     = 1'b0;
         nonempty_in[level_ff] = 1'b0;
      end
      if (cmd.finish_link) begin
         queued_in[head_e] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         queued_ff   <= '0;
         nonempty_ff <= '0;
      end else begin
         queued_ff   <= queued_in;
         nonempty_ff <= nonempty_in;
      end
   end

   always_comb begin
      priority if (cmd.finish_link) begin
         res_status = RSP_DONE;
         res_id     = head_rd_ff;
      end else if (is_disp) begin
         res_status = found_ff ? RSP_DONE : RSP_EMPTY;
         res_id     = found_ff ? head_rd_ff : '0;
      end else if (!is_enq || !range_ok_ff) begin
         res_status = RSP_DONE;
         res_id     = id_ff;
      end else if (is_dup) begin
         res_status = RSP_DUP;
         res_id     = id_ff;
      end else begin
         res_status = RSP_DONE;
         res_id     = id_ff;
      end
   end

   // result register: a new result may replace one that transfers this cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish || cmd.finish_link) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish || cmd.finish_link) begin
         rsp_status_ff <= res_status;
         rsp_chosen_ff <= res_id;
      end
   end

   assign stat.disp_link = is_disp && found_ff && (head_rd_ff != tail_rd_ff);
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_chosen_id = rsp_chosen_ff;

endmodule

`default_nettype wire

// ===== verif/mprq_tb_pkg.sv =====
`default_nettype none

package mprq_tb_pkg;

   import mprq_pkg::*;

   localparam int ENTRY_COUNT = 16;
   localparam int LEVEL_COUNT = 8;

   // func code that the block treats as a no-op
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      mprq_rsp_type    status;
      logic [ID_W-1:0] chosen_id;
   } mprq_result_type;

   class ready_queue_scoreboard;

      logic [ID_W-1:0]        link_of [ENTRY_COUNT];
      logic [ID_W-1:0]        head_of [LEVEL_COUNT];
      logic [ID_W-1:0]        tail_of [LEVEL_COUNT];
      bit   [LEVEL_COUNT-1:0] level_busy;
      bit   [ENTRY_COUNT-1:0] queued;
      mprq_result_type        expected_results[$];
      int                     errors;

      function new();
         level_busy = '0;
         queued     = '0;
         errors     = 0;
         foreach (link_of[i]) link_of[i] = '0;
         foreach (head_of[i]) head_of[i] = '0;
         foreach (tail_of[i]) tail_of[i] = '0;
      endfunction

      function bit is_queued(logic [ID_W-1:0] id);
         return queued[id];
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Update the queue state for one accepted request and note its result.
      function void note_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                                 logic [LEVEL_W-1:0] lvl);
         mprq_result_type res;
         logic [ID_W-1:0] h;
         bit              found;
         res.status    = RSP_DONE;
         res.chosen_id = id;
         found         = 1'b0;
         if (func == FUNC_DISPATCH) begin
            res.status    = RSP_EMPTY;
            res.chosen_id = '0;
            for (int lv = 0; lv < LEVEL_COUNT; lv++) begin
               if (!found && level_busy[lv]) begin
                  found = 1'b1;
                  h = head_of[lv];
                  if (h == tail_of[lv])
                     level_busy[lv] = 1'b0;
                  else
                     head_of[lv] = link_of[h];
                  queued[h]     = 1'b0;
                  res.status    = RSP_DONE;
                  res.chosen_id = h;
               end
            end
         end else if (func != FUNC_UNUSED && int'(id) < ENTRY_COUNT &&
                      int'(lvl) < LEVEL_COUNT) begin
            if (queued[id]) begin
               res.status = RSP_DUP;
            end else begin
               if (!level_busy[lvl]) begin
                  head_of[lvl]    = id;
                  tail_of[lvl]    = id;
                  level_busy[lvl] = 1'b1;
               end else if (func == FUNC_ENQ_TAIL) begin
                  link_of[tail_of[lvl]] = id;
                  tail_of[lvl]          = id;
               end else begin
                  link_of[id]  = head_of[lvl];
                  head_of[lvl] = id;
               end
               queued[id] = 1'b1;
            end
         end
         expected_results.push_back(res);
      endfunction

      function void check_result(logic [STATUS_W-1:0] status, logic [ID_W-1:0] id);
         mprq_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with nothing pending: status %0d chosen_id %0d", status, id);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
         end
         if (id !== want.chosen_id) begin
            $error("chosen_id: expected %0d, actual %0d", want.chosen_id, id);
            errors++;
         end
      endfunction

   endclass

endpackage

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top
   import mprq_pkg::*;
   import mprq_tb_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [ID_W-1:0]     req_proc_id;
   logic [LEVEL_W-1:0]  req_proc_level;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_chosen_id;

   int idle_pct  = 0;
   int stall_pct = 0;

   ready_queue_scoreboard sb = new();

   multilevel_priority_ready_queue_unit #(
      .NUM_ENTRIES (ENTRY_COUNT),
      .NUM_LEVELS  (LEVEL_COUNT)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_proc_id    (req_proc_id),
      .req_proc_level (req_proc_level),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_chosen_id  (rsp_chosen_id)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("Regression FAIL");
      $finish;
   end

   // Check results before noting new requests so a stray result is flagged.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_status, rsp_chosen_id);
         if (req_valid && !req_stall)
            sb.note_request(req_func, req_proc_id, req_proc_level);
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id,
                               logic [LEVEL_W-1:0] lvl);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_proc_id    <= id;
      req_proc_level <= lvl;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_dispatch();
      send_request(FUNC_DISPATCH, ID_W'($urandom), LEVEL_W'($urandom));
   endtask

   task automatic run_directed();
      send_request(FUNC_DISPATCH, 4'd15, 3'd7);   // nothing queued
      send_request(FUNC_ENQ_TAIL, 4'd0, 3'd7);
      send_request(FUNC_ENQ_TAIL, 4'd15, 3'd7);
      send_request(FUNC_ENQ_HEAD, 4'd5, 3'd7);
      send_request(FUNC_ENQ_TAIL, 4'd15, 3'd2);   // already queued
      send_request(FUNC_UNUSED, 4'd9, 3'd3);
      send_request(FUNC_ENQ_HEAD, 4'd10, 3'd0);
      send_request(FUNC_ENQ_TAIL, 4'd3, 3'd0);
      send_request(FUNC_ENQ_HEAD, 4'd7, 3'd0);
      send_request(FUNC_ENQ_TAIL, 4'd12, 3'd4);
      repeat (6) send_dispatch();
      send_request(FUNC_ENQ_TAIL, 4'd7, 3'd7);
      send_dispatch();
      send_dispatch();
      send_request(FUNC_DISPATCH, 4'd0, 3'd0);    // drained again
      send_request(FUNC_UNUSED, 4'd15, 3'd7);
      send_request(FUNC_ENQ_HEAD, 4'd15, 3'd0);
      send_dispatch();
   endtask

   // Mostly enqueue free entries and dispatch; the bias drifts so the levels
   // fill up and drain repeatedly.
   task automatic run_random(int count);
      int              fill_bias;
      int              r;
      int              start;
      logic [ID_W-1:0] id;
      fill_bias = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 24 == 0)
            fill_bias = $urandom_range(75, 30);
         r = $urandom_range(99);
         if (r < fill_bias) begin
            id = ID_W'($urandom);
            if ($urandom_range(9) != 0) begin
               start = $urandom_range(ENTRY_COUNT - 1);
               for (int k = 0; k < ENTRY_COUNT; k++) begin
                  if (!sb.is_queued(ID_W'(start + k))) begin
                     id = ID_W'(start + k);
                     break;
                  end
               end
            end
            send_request($urandom_range(2) == 0 ? FUNC_ENQ_HEAD : FUNC_ENQ_TAIL, id,
                         $urandom_range(3) == 0 ? LEVEL_W'($urandom)
                                                : LEVEL_W'($urandom_range(2)));
         end else if (r < 96) begin
            send_dispatch();
         end else begin
            send_request(FUNC_UNUSED, ID_W'($urandom), LEVEL_W'($urandom));
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_ENQ_TAIL;
      req_proc_id    = '0;
      req_proc_level = '0;
      rsp_stall      = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_random(312);
      idle_pct = 81;
      run_random(312);
      idle_pct  = 0;
      stall_pct = 81;
      run_random(313);
      idle_pct  = 38;
      stall_pct = 38;
      run_random(313);
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
